// ===== design/ggc_pkg.sv =====
// ----------------------------------------------------------------------------
// ggc_pkg: shared types and constants for the graph coloring block
// Item kinds, field widths, and the command/status bundles that join the
// controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package ggc_pkg;

   // Field widths fixed by the item format
   localparam int VID_W        = 5;   // vertex number
   localparam int COLOR_W      = 5;   // color number
   localparam int KIND_W       = 2;   // item kind
   localparam int CNT_W        = 6;   // vertex count register
   localparam int NUM_COLORS   = 32;  // colors a 5-bit field can name
   localparam int RESULT_LIMIT = 32;  // most results one run may give

   localparam logic [CNT_W-1:0] CNT_RESET = 6'd32;

   // Item kinds
   localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd0;
   localparam logic [KIND_W-1:0] KIND_EDGE  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_COLOR = 2'd2;

   // Adjacency read address select
   typedef enum logic [1:0] {
      RD_FIRST = 2'd0,   // row of vertex 0
      RD_NEXT  = 2'd1,   // row of the vertex after the current one
      RD_FROM  = 2'd2,   // row of the first edge end
      RD_TO    = 2'd3    // row of the edge_to end
   } rd_sel_type;

   // Controller to datapath
   typedef struct packed {
      logic       load_req;   // capture the edge ends of an accepted item
      logic       clear;      // empty the adjacency matrix
      logic       run_start;  // restart the vertex counter and colored mask
      logic       rd_en;      // read one adjacency row
      rd_sel_type rd_sel;
      logic       wr_en;      // write one adjacency row
      logic       wr_to;      // 0: row of first end, 1: row of second end
      logic       emit;       // color the current vertex and load the result
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic edge_ok;   // captured edge is not a self-loop and is in range
      logic n_zero;    // no vertex takes part in a run
      logic is_last;   // current vertex is the final one of the run
   } status_type;

endpackage

`default_nettype wire

// ===== design/ggc_chan_if.sv =====
// ----------------------------------------------------------------------------
// ggc_chan_if: valid/ready channels of the graph coloring block
// Request, response and register-write channels, each with a source and a
// sink modport.
// ----------------------------------------------------------------------------
`default_nettype none

interface ggc_req_if;
   logic                        valid;
   logic                        ready;
   logic [ggc_pkg::KIND_W-1:0]  kind;
   logic [ggc_pkg::VID_W-1:0]   edge_from;
   logic [ggc_pkg::VID_W-1:0]   edge_to;

   modport source (output valid, output kind, output edge_from, output edge_to,
                   input ready);
   modport sink   (input valid, input kind, input edge_from, input edge_to,
                   output ready);
endinterface

interface ggc_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [ggc_pkg::VID_W-1:0]   vertex;
   logic [ggc_pkg::COLOR_W-1:0] color;
   logic                        last;

   modport source (output valid, output vertex, output color, output last,
                   input ready);
   modport sink   (input valid, input vertex, input color, input last,
                   output ready);
endinterface

interface ggc_csr_if;
   logic                        valid;
   logic                        ready;
   logic [ggc_pkg::CNT_W-1:0]   vertex_count;

   modport source (output valid, output vertex_count, input ready);
   modport sink   (input valid, input vertex_count, output ready);
endinterface

`default_nettype wire

// ===== design/ggc_ctrl.sv =====
// ----------------------------------------------------------------------------
// ggc_ctrl: sequencer of the graph coloring block
// Decodes accepted items, steps the edge read-modify-write and the coloring
// run, and owns the response valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module ggc_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic [ggc_pkg::KIND_W-1:0] req_kind,
   output logic                       req_ready,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  ggc_pkg::status_type        st,
   output ggc_pkg::cmd_type           cmd
);

   typedef enum logic [4:0] {
      ST_IDLE    = 5'b00001,
      ST_EDGE_RD = 5'b00010,
      ST_EDGE_WA = 5'b00100,
      ST_EDGE_WB = 5'b01000,
      ST_RUN     = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_vld_ff, rsp_vld_in;
   logic      slot_free;

   // Result register can take a new result this cycle
   assign slot_free = !rsp_vld_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_vld_ff;

   // Next state and commands
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               unique case (req_kind)
                  ggc_pkg::KIND_CLEAR: begin
                     cmd.clear = 1'b1;
                  end
                  ggc_pkg::KIND_EDGE: begin
                     state_in = ST_EDGE_RD;
                  end
                  ggc_pkg::KIND_COLOR: begin
                     if (!st.n_zero) begin
                        cmd.run_start = 1'b1;
                        cmd.rd_en     = 1'b1;
                        cmd.rd_sel    = ggc_pkg::RD_FIRST;
                        state_in      = ST_RUN;
                     end
                  end
                  default: ;  // unused kind: drop
               endcase
            end
         end
         ST_EDGE_RD: begin
            if (st.edge_ok) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = ggc_pkg::RD_FROM;
               state_in   = ST_EDGE_WA;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_EDGE_WA: begin
            // write first row, fetch second row
            cmd.wr_en  = 1'b1;
            cmd.wr_to  = 1'b0;
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = ggc_pkg::RD_TO;
            state_in   = ST_EDGE_WB;
         end
         ST_EDGE_WB: begin
            cmd.wr_en = 1'b1;
            cmd.wr_to = 1'b1;
            state_in  = ST_IDLE;
         end
         ST_RUN: begin
            // one vertex per cycle while the result register drains
            if (slot_free) begin
               cmd.emit = 1'b1;
               if (st.is_last) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.rd_en  = 1'b1;
                  cmd.rd_sel = ggc_pkg::RD_NEXT;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Response valid: set on emit, drop on transfer
   always_comb begin
      if (cmd.emit) begin
         rsp_vld_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_vld_in = 1'b0;
      end else begin
         rsp_vld_in = rsp_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/ggc_dpath.sv =====
// ----------------------------------------------------------------------------
// ggc_dpath: datapath of the graph coloring block
// Adjacency row memory with per-row valid bits, vertex color store,
// colored mask, first-fit color pick and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ggc_dpath #(
   parameter int MAX_VERTICES = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [ggc_pkg::VID_W-1:0]   req_edge_from,
   input  logic [ggc_pkg::VID_W-1:0]   req_edge_to,
   input  logic                        csr_valid,
   input  logic [ggc_pkg::CNT_W-1:0]   csr_vertex_count,
   input  ggc_pkg::cmd_type            cmd,
   output ggc_pkg::status_type         st,
   output logic [ggc_pkg::VID_W-1:0]   rsp_vertex,
   output logic [ggc_pkg::COLOR_W-1:0] rsp_color,
   output logic                        rsp_last
);

   localparam int VW  = $clog2(MAX_VERTICES);
   localparam int LIM = (MAX_VERTICES < ggc_pkg::RESULT_LIMIT) ?
                        MAX_VERTICES : ggc_pkg::RESULT_LIMIT;
   localparam logic [MAX_VERTICES-1:0] ROW_ONE = MAX_VERTICES'(1);
   localparam logic [ggc_pkg::NUM_COLORS-1:0] COLOR_ONE = ggc_pkg::NUM_COLORS'(1);

   // Registers
   logic [ggc_pkg::VID_W-1:0]   from_ff, to_ff;
   logic [ggc_pkg::CNT_W-1:0]   count_ff;
   logic [ggc_pkg::CNT_W-1:0]   u_ff;
   logic [MAX_VERTICES-1:0]     adj_mem [MAX_VERTICES];
   logic [MAX_VERTICES-1:0]     row_vld_ff;
   logic [MAX_VERTICES-1:0]     rd_row_ff;
   logic                        rd_vld_ff;
   logic [MAX_VERTICES-1:0]     colored_ff;
   logic [ggc_pkg::COLOR_W-1:0] vcol_ff [MAX_VERTICES];
   logic [ggc_pkg::VID_W-1:0]   rsp_vertex_ff;
   logic [ggc_pkg::COLOR_W-1:0] rsp_color_ff;
   logic                        rsp_last_ff;

   // Combinational
   logic [ggc_pkg::CNT_W-1:0]      n_eff;
   logic [ggc_pkg::CNT_W-1:0]      u_next;
   logic [VW-1:0]                  from_idx, to_idx, u_idx, next_idx;
   logic [VW-1:0]                  rd_addr, wr_addr;
   logic [MAX_VERTICES-1:0]        row_eff, wr_data, nb;
   logic [ggc_pkg::NUM_COLORS-1:0] used, free, low;
   logic [ggc_pkg::COLOR_W-1:0]    color_new;

   // Capture edge ends of an accepted item
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         from_ff <= req_edge_from;
         to_ff   <= req_edge_to;
      end
   end

   // Vertex count register
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= ggc_pkg::CNT_RESET;
      end else if (csr_valid) begin
         count_ff <= csr_vertex_count;
      end
   end

   // Saturate the count to the rows that exist
   assign n_eff  = (int'(count_ff) > LIM) ? ggc_pkg::CNT_W'(LIM) : count_ff;
   assign u_next = u_ff + 1'b1;

   assign from_idx = VW'(from_ff);
   assign to_idx   = VW'(to_ff);
   assign u_idx    = VW'(u_ff);
   assign next_idx = VW'(u_next);

   assign st.edge_ok = (from_ff != to_ff) && (int'(from_ff) < MAX_VERTICES) &&
                       (int'(to_ff) < MAX_VERTICES);
   assign st.n_zero  = (n_eff == '0);
   assign st.is_last = (u_next == n_eff);

   // Read address select
   always_comb begin
      unique case (cmd.rd_sel)
         ggc_pkg::RD_FIRST: rd_addr = '0;
         ggc_pkg::RD_NEXT:  rd_addr = next_idx;
         ggc_pkg::RD_FROM:  rd_addr = from_idx;
         ggc_pkg::RD_TO:    rd_addr = to_idx;
      endcase
   end

   // Row that was read; a row not written since the last clear reads as empty
   assign row_eff = rd_vld_ff ? rd_row_ff : '0;

   // Edge update: set the other end's bit in the row just read
   assign wr_addr = cmd.wr_to ? to_idx : from_idx;
   assign wr_data = row_eff | (ROW_ONE << (cmd.wr_to ? from_ff : to_ff));

   // Adjacency memory: one write and one registered read a cycle
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         adj_mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_row_ff <= adj_mem[rd_addr];
         rd_vld_ff <= row_vld_ff[rd_addr];
      end
   end

   // Row valid bits: clear empties the whole matrix at once
   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         row_vld_ff <= '0;
      end else if (cmd.wr_en) begin
         row_vld_ff[wr_addr] <= 1'b1;
      end
   end

   // Mark colors of already-colored neighbours
   assign nb = row_eff & colored_ff;

   always_comb begin
      used = '0;
      for (int v = 0; v < MAX_VERTICES; v++) begin
         if (nb[v]) begin
            used = used | (COLOR_ONE << vcol_ff[v]);
         end
      end
   end

   // Lowest free color: isolate the lowest set bit, then encode it
   assign free = ~used;
   assign low  = free & (~free + 1'b1);

   always_comb begin
      color_new = '0;
      for (int i = 0; i < ggc_pkg::NUM_COLORS; i++) begin
         if (low[i]) begin
            color_new = color_new | ggc_pkg::COLOR_W'(i);
         end
      end
   end

   // Vertex counter and colored mask
   always_ff @(posedge clock) begin
      if (reset) begin
         u_ff       <= '0;
         colored_ff <= '0;
      end else if (cmd.run_start) begin
         u_ff       <= '0;
         colored_ff <= '0;
      end else if (cmd.emit) begin
         u_ff              <= u_next;
         colored_ff[u_idx] <= 1'b1;
      end
   end

   // Color store and result register
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         vcol_ff[u_idx] <= color_new;
         rsp_vertex_ff  <= u_ff[ggc_pkg::VID_W-1:0];
         rsp_color_ff   <= color_new;
         rsp_last_ff    <= st.is_last;
      end
   end

   assign rsp_vertex = rsp_vertex_ff;
   assign rsp_color  = rsp_color_ff;
   assign rsp_last   = rsp_last_ff;

endmodule

`default_nettype wire

// ===== design/greedy_graph_coloring_top.sv =====
// ----------------------------------------------------------------------------
// greedy_graph_coloring_top: first-fit coloring of a small undirected graph
// Holds the graph as an adjacency bit matrix and colors vertices in order.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries one item per transfer: kind 0 empties the graph, kind 1
//   adds the undirected edge edge_from/edge_to (self-loops and vertices at or
//   above MAX_VERTICES are dropped), kind 2 colors vertices 0..n-1 with n the
//   vertex count, limited to MAX_VERTICES and 32. Kind 3 is dropped.
//   csr_ch writes the vertex count; write it only while the block is idle.
//   rsp_ch gives one transfer per vertex of a run: vertex, color, and last on
//   the final vertex. Clear and edge items give no response.
// Timing:
//   A clear is done as it is accepted. An edge goes through EDGE_RD, EDGE_WA
//   and EDGE_WB: a row read-modify-write on each end through the adjacency
//   memory's one read and one write port. A run reads row 0 on accept, then
//   one row per vertex, giving one result per cycle while the result register
//   drains. A stalled response holds in the result register and pauses the
//   run; the next item is taken once the final vertex is in that register.
// Reset: the graph is empty, the vertex count is 32, no response is pending.
// ----------------------------------------------------------------------------
`default_nettype none

module greedy_graph_coloring_top #(
   parameter int MAX_VERTICES = 32
) (
   input  logic      clock,
   input  logic      reset,
   ggc_req_if.sink   req_ch,
   ggc_rsp_if.source rsp_ch,
   ggc_csr_if.sink   csr_ch
);

   ggc_pkg::cmd_type    cmd;
   ggc_pkg::status_type st;

   // Register writes are always taken
   assign csr_ch.ready = 1'b1;

   ggc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_kind  (req_ch.kind),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .st        (st),
      .cmd       (cmd)
   );

   ggc_dpath #(
      .MAX_VERTICES (MAX_VERTICES)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .req_edge_from    (req_ch.edge_from),
      .req_edge_to      (req_ch.edge_to),
      .csr_valid        (csr_ch.valid),
      .csr_vertex_count (csr_ch.vertex_count),
      .cmd              (cmd),
      .st               (st),
      .rsp_vertex       (rsp_ch.vertex),
      .rsp_color        (rsp_ch.color),
      .rsp_last         (rsp_ch.last)
   );

endmodule

`default_nettype wire

// ===== design/ggc_checker.sv =====
// ----------------------------------------------------------------------------
// ggc_checker: port-level checks for the graph coloring block
// Watches the top level's channels and flags behavior the design rules out.
// ----------------------------------------------------------------------------
`default_nettype none

module ggc_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [ggc_pkg::VID_W-1:0]   rsp_vertex,
   input logic [ggc_pkg::COLOR_W-1:0] rsp_color,
   input logic                        rsp_last
);

   // A stalled response stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response valid dropped while stalled");

   // First fit never picks a color above the number of earlier vertices
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_color <= rsp_vertex)
      else $error("color exceeds vertex number");

   // A run still has vertices to go after a non-final transfer
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |-> !req_ready)
      else $error("request taken in the middle of a run");

   // Nothing is offered right after reset
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind greedy_graph_coloring_top ggc_checker u_ggc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_ready  (req_ch.ready),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .rsp_vertex (rsp_ch.vertex),
   .rsp_color  (rsp_ch.color),
   .rsp_last   (rsp_ch.last)
);

`default_nettype wire

// ===== verif/greedy_graph_coloring_top_tb.sv =====
// ----------------------------------------------------------------------------
// greedy_graph_coloring_top_tb: self-checking bench for the coloring block
// Builds graphs with edge and clear items, runs first-fit coloring under
// several vertex counts, and checks every vertex/color/last transfer against
// a first-fit predictor. Requests idle and responses stall at random.
// ----------------------------------------------------------------------------

typedef struct {
   logic [ggc_pkg::VID_W-1:0]   vertex;
   logic [ggc_pkg::COLOR_W-1:0] color;
   logic                        last;
} color_result_type;

// Track the graph and vertex count, predict each run, check the transfers
class color_checker;
   int                          max_vertices;
   logic [31:0]                 adj_rows [32];
   logic [ggc_pkg::COLOR_W-1:0] vertex_color [32];
   logic [ggc_pkg::CNT_W-1:0]   count_reg;
   color_result_type            pending_colors [$];
   int                          errors;

   function new(int max_v);
      max_vertices = max_v;
      foreach (adj_rows[i]) adj_rows[i] = '0;
      foreach (vertex_color[i]) vertex_color[i] = '0;
      count_reg = ggc_pkg::CNT_RESET;
      errors = 0;
   endfunction

   function void set_count(logic [ggc_pkg::CNT_W-1:0] value);
      count_reg = value;
   endfunction

   // Lowest color not taken by an earlier vertex of the run that is adjacent
   function void first_fit_run();
      int               n;
      int               c;
      logic [63:0]      used;
      color_result_type res;
      n = int'(count_reg);
      if (n > max_vertices) n = max_vertices;
      if (n > ggc_pkg::RESULT_LIMIT) n = ggc_pkg::RESULT_LIMIT;
      for (int u = 0; u < n; u++) begin
         used = '0;
         for (int v = 0; v < u; v++) begin
            if (adj_rows[u][v]) used[vertex_color[v]] = 1'b1;
         end
         c = 0;
         while (c < 63 && used[c]) c++;
         vertex_color[u] = c[ggc_pkg::COLOR_W-1:0];
         res.vertex = u[ggc_pkg::VID_W-1:0];
         res.color  = c[ggc_pkg::COLOR_W-1:0];
         res.last   = (u == n - 1);
         pending_colors.push_back(res);
      end
   endfunction

   // Apply one accepted request to the graph; queue the colors of a run
   function void note_item(logic [ggc_pkg::KIND_W-1:0] kind,
                           logic [ggc_pkg::VID_W-1:0] a,
                           logic [ggc_pkg::VID_W-1:0] b);
      case (kind)
         ggc_pkg::KIND_CLEAR: begin
            foreach (adj_rows[i]) adj_rows[i] = '0;
         end
         ggc_pkg::KIND_EDGE: begin
            if (a != b && int'(a) < max_vertices && int'(b) < max_vertices) begin
               adj_rows[a][b] = 1'b1;
               adj_rows[b][a] = 1'b1;
            end
         end
         ggc_pkg::KIND_COLOR: first_fit_run();
         default: ;
      endcase
   endfunction

   function void report(string what, int want, int got);
      errors++;
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want, got);
   endfunction

   // Compare one response transfer with the oldest queued color
   function void check_color(logic [ggc_pkg::VID_W-1:0] vertex,
                             logic [ggc_pkg::COLOR_W-1:0] color,
                             logic last);
      color_result_type want;
      if (pending_colors.size() == 0) begin
         errors++;
         $display("%0t: unexpected result: expected none, got vertex %0d color %0d last %0d",
                  $time, vertex, color, last);
         return;
      end
      want = pending_colors.pop_front();
      if (vertex !== want.vertex) report("vertex", int'(want.vertex), int'(vertex));
      if (color !== want.color) report("color", int'(want.color), int'(color));
      if (last !== want.last) report("last", int'(want.last), int'(last));
   endfunction
endclass

module greedy_graph_coloring_top_tb;

   localparam int PERIOD        = 12;
   localparam int NUM_VERT      = 32;
   localparam int ITEM_TARGET   = 200;
   localparam int SETTLE_CYCLES = 10;
   localparam logic [ggc_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;

   logic clock;
   logic reset;

   ggc_req_if req_ch ();
   ggc_rsp_if rsp_ch ();
   ggc_csr_if csr_ch ();

   greedy_graph_coloring_top #(
      .MAX_VERTICES(NUM_VERT)
   ) u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   color_checker sb;
   int           burst_left;
   int           items_sent;
   int           rsp_mode;
   int           rsp_window;
   int           rsp_cycle;

   initial clock = 1'b0;
   always #(PERIOD / 2) clock = ~clock;

   // Check accepted results; stall the response channel on its own pattern
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         sb.check_color(rsp_ch.vertex, rsp_ch.color, rsp_ch.last);
      rsp_cycle++;
      if (rsp_window == 0) begin
         rsp_mode   = $urandom_range(0, 3);
         rsp_window = $urandom_range(16, 80);
      end else begin
         rsp_window--;
      end
      case (rsp_mode)
         0: rsp_ch.ready <= 1'b1;
         1: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
         2: rsp_ch.ready <= (rsp_cycle % 3 != 0);
         default: rsp_ch.ready <= ($urandom_range(0, 4) == 0);
      endcase
   end

   // Hold one request until its transfer; open a new burst, most often after a gap
   task automatic send_request(logic [ggc_pkg::KIND_W-1:0] kind,
                               logic [ggc_pkg::VID_W-1:0] a,
                               logic [ggc_pkg::VID_W-1:0] b);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 10);
      end
      burst_left--;
      req_ch.valid     <= 1'b1;
      req_ch.kind      <= kind;
      req_ch.edge_from <= a;
      req_ch.edge_to   <= b;
      do @(posedge clock); while (!(req_ch.valid && req_ch.ready));
      sb.note_item(kind, a, b);
      items_sent++;
   endtask

   // Drop the request, drain expected colors, let a pending edge finish
   task automatic settle();
      req_ch.valid <= 1'b0;
      burst_left = 0;
      while (sb.pending_colors.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_count(logic [ggc_pkg::CNT_W-1:0] value);
      settle();
      csr_ch.valid        <= 1'b1;
      csr_ch.vertex_count <= value;
      do @(posedge clock); while (!(csr_ch.valid && csr_ch.ready));
      csr_ch.valid <= 1'b0;
      sb.set_count(value);
   endtask

   function automatic logic [ggc_pkg::VID_W-1:0] any_vertex();
      return ggc_pkg::VID_W'($urandom_range(0, 31));
   endfunction

   function automatic logic [ggc_pkg::VID_W-1:0] pick_vertex(int n);
      if ($urandom_range(0, 4) == 0) return any_vertex();
      return ggc_pkg::VID_W'($urandom_range(0, n - 1));
   endfunction

   // Build one random graph (sometimes a clique) and usually color it
   task automatic random_graph_run(int n);
      int s;
      int base;
      int k;
      if ($urandom_range(0, 9) < 7)
         send_request(ggc_pkg::KIND_CLEAR, any_vertex(), any_vertex());
      if (n >= 3 && $urandom_range(0, 6) == 0) begin
         s    = $urandom_range(3, (n < 8) ? n : 8);
         base = $urandom_range(0, n - s);
         for (int i = 0; i < s; i++)
            for (int j = i + 1; j < s; j++)
               if ($urandom_range(0, 1) == 0)
                  send_request(ggc_pkg::KIND_EDGE, ggc_pkg::VID_W'(base + i),
                               ggc_pkg::VID_W'(base + j));
               else
                  send_request(ggc_pkg::KIND_EDGE, ggc_pkg::VID_W'(base + j),
                               ggc_pkg::VID_W'(base + i));
      end else begin
         k = $urandom_range(1, 10);
         for (int i = 0; i < k; i++) begin
            if ($urandom_range(0, 9) == 0) begin
               if ($urandom_range(0, 1) == 0)
                  send_request(KIND_UNUSED, any_vertex(), any_vertex());
               else begin
                  s = $urandom_range(0, 31);
                  send_request(ggc_pkg::KIND_EDGE, ggc_pkg::VID_W'(s), ggc_pkg::VID_W'(s));
               end
            end
            send_request(ggc_pkg::KIND_EDGE, pick_vertex(n), pick_vertex(n));
         end
      end
      if ($urandom_range(0, 9) != 0)
         send_request(ggc_pkg::KIND_COLOR, any_vertex(), any_vertex());
   endtask

   // Main sequence: reset, directed cases, random phases, drain, verdict
   initial begin
      int                        r;
      int                        n_eff;
      logic [ggc_pkg::CNT_W-1:0] count;
      sb                  = new(NUM_VERT);
      burst_left          = 0;
      items_sent          = 0;
      rsp_mode            = 0;
      rsp_window          = 0;
      rsp_cycle           = 0;
      reset               = 1'b1;
      req_ch.valid        = 1'b0;
      req_ch.kind         = ggc_pkg::KIND_CLEAR;
      req_ch.edge_from    = '0;
      req_ch.edge_to      = '0;
      rsp_ch.ready        = 1'b0;
      csr_ch.valid        = 1'b0;
      csr_ch.vertex_count = ggc_pkg::CNT_RESET;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Empty graph at the reset count: every vertex takes color 0
      send_request(ggc_pkg::KIND_COLOR, 5'd0, 5'd0);
      // Extreme vertices, a duplicate edge, a self-loop, an unused kind
      send_request(ggc_pkg::KIND_EDGE, 5'd0, 5'd31);
      send_request(ggc_pkg::KIND_EDGE, 5'd31, 5'd0);
      send_request(ggc_pkg::KIND_EDGE, 5'd7, 5'd7);
      send_request(KIND_UNUSED, 5'd31, 5'd31);
      send_request(ggc_pkg::KIND_EDGE, 5'd0, 5'd1);
      send_request(ggc_pkg::KIND_EDGE, 5'd1, 5'd31);
      send_request(ggc_pkg::KIND_EDGE, 5'd30, 5'd31);
      send_request(ggc_pkg::KIND_COLOR, 5'd31, 5'd0);
      // Count of zero gives no result; an oversized count saturates
      write_count(6'd0);
      send_request(ggc_pkg::KIND_COLOR, 5'd0, 5'd31);
      write_count(6'd63);
      send_request(ggc_pkg::KIND_COLOR, 5'd31, 5'd31);
      write_count(6'd1);
      send_request(ggc_pkg::KIND_COLOR, 5'd0, 5'd0);
      // Edge beyond the count is kept and shows once the count grows
      write_count(6'd3);
      send_request(ggc_pkg::KIND_EDGE, 5'd2, 5'd20);
      send_request(ggc_pkg::KIND_EDGE, 5'd2, 5'd1);
      send_request(ggc_pkg::KIND_COLOR, 5'd0, 5'd0);
      write_count(6'd33);
      send_request(ggc_pkg::KIND_COLOR, 5'd0, 5'd0);
      send_request(ggc_pkg::KIND_CLEAR, 5'd31, 5'd31);
      send_request(ggc_pkg::KIND_COLOR, 5'd0, 5'd0);

      // Random phases, each under its own vertex count
      while (items_sent < ITEM_TARGET) begin
         r = $urandom_range(0, 19);
         case (r)
            0: count = 6'd32;
            1: count = 6'd1;
            2: count = ggc_pkg::CNT_W'($urandom_range(33, 63));
            3: count = 6'd0;
            default: count = ggc_pkg::CNT_W'($urandom_range(2, 12));
         endcase
         write_count(count);
         if (count == '0 || int'(count) > NUM_VERT) begin
            n_eff = NUM_VERT;
         end else begin
            n_eff = int'(count);
         end
         repeat ($urandom_range(1, 3)) random_graph_run(n_eff);
      end

      settle();
      if (sb.errors == 0) begin
         $display("PASS greedy_graph_coloring_top");
      end else begin
         $display("FAIL greedy_graph_coloring_top");
      end
      $finish;
   end

   // Stop a hung run
   initial begin
      #(PERIOD * 400000);
      $display("FAIL greedy_graph_coloring_top");
      $finish;
   end

endmodule

// ===== filelist.f =====
design/ggc_pkg.sv
design/ggc_chan_if.sv
design/ggc_ctrl.sv
design/ggc_dpath.sv
design/greedy_graph_coloring_top.sv
design/ggc_checker.sv
verif/greedy_graph_coloring_top_tb.sv
